/* hdl/range_sweep_object_segmenter_macros.svh */
// ---------------------------------------------------------------------------
// Range sweep object segmenter assertion macros
// Shared concurrent assertion helpers; empty when synthesizing.
// ---------------------------------------------------------------------------
`ifndef RANGE_SWEEP_OBJECT_SEGMENTER_MACROS_SVH
`define RANGE_SWEEP_OBJECT_SEGMENTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RSS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
// next-cycle implication
`define RSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define RSS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hdl/rss_pkg.sv */
// ---------------------------------------------------------------------------
// rss_pkg
// Types and constants shared by the range sweep object segmenter.
// ---------------------------------------------------------------------------
package rss_pkg;

   localparam int DIST_W       = 16;
   localparam int CFG_DIST_W   = 16;
   localparam int CFG_WIDTH_W  = 8;
   localparam int RUN_W        = 8;
   localparam int NUM_W        = 8;
   localparam int OUT_ANGLE_W  = 8;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 16;
   localparam int RSP_DATA_W   = 40;

   localparam int ANGLE_BITS_DEFAULT = 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic [CFG_DIST_W-1:0]  MAX_RANGE_RESET = 16'd4000;
   localparam logic [CFG_DIST_W-1:0]  NEAR_TOL_RESET  = 16'd48;
   localparam logic [CFG_DIST_W-1:0]  FAR_TOL_RESET   = 16'd64;
   localparam logic [CFG_WIDTH_W-1:0] MIN_WIDTH_RESET = 8'd7;
   localparam logic [DIST_W-1:0]      SAMPLE_RESET    = 16'd4000;
   localparam logic [RUN_W-1:0]       RUN_MAX         = 8'd254;
   localparam logic [NUM_W-1:0]       COUNT_MAX       = 8'd255;
   localparam logic [RUN_W-1:0]       BEST_WIDTH_RESET = 8'hFF;

   localparam logic KIND_OBJECT   = 1'b0;
   localparam logic KIND_SMALLEST = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_RANGE = 8'd0,
      CSR_NEAR_TOL  = 8'd1,
      CSR_FAR_TOL   = 8'd2,
      CSR_MIN_WIDTH = 8'd3
   } rss_csr_type;

   typedef struct packed {
      logic                   kind;
      logic [NUM_W-1:0]       object_number;
      logic [OUT_ANGLE_W-1:0] angle;
      logic [DIST_W-1:0]      object_distance;
      logic [RUN_W-1:0]       width;
      logic                   final_of_run;
   } rss_result_type;

   // up to two results per sample, in order; a single one sits in first
   typedef struct packed {
      logic [1:0]     count;
      rss_result_type first;
      rss_result_type second;
   } rss_push_type;

endpackage

/* hdl/rss_front.sv */
// ---------------------------------------------------------------------------
// rss_front
// Classifies each sample, tracks runs and the narrowest object, and
// produces the result records for the queue.
// ---------------------------------------------------------------------------
`include "range_sweep_object_segmenter_macros.svh"

module rss_front #(
   parameter int ANGLE_BITS = rss_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [rss_pkg::DIST_W-1:0]        distance,
   input  logic                              end_of_sweep,
   input  logic                              csr_write,
   input  logic [rss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rss_pkg::CSR_DATA_W-1:0]    csr_data,
   output rss_pkg::rss_push_type             push
);
   import rss_pkg::*;

   logic [CFG_DIST_W-1:0]  max_range_ff, max_range_in;
   logic [CFG_DIST_W-1:0]  near_tol_ff, near_tol_in;
   logic [CFG_DIST_W-1:0]  far_tol_ff, far_tol_in;
   logic [CFG_WIDTH_W-1:0] min_width_ff, min_width_in;

   logic [DIST_W-1:0]     prev_sample_ff, prev_sample_in;
   logic [DIST_W-1:0]     prev_prev_ff, prev_prev_in;
   logic                  in_object_ff, in_object_in;
   logic [RUN_W-1:0]      run_length_ff, run_length_in;
   logic [ANGLE_BITS-1:0] run_start_ff, run_start_in;
   logic [NUM_W-1:0]      object_count_ff, object_count_in;
   logic [ANGLE_BITS-1:0] sample_angle_ff, sample_angle_in;
   logic [RUN_W-1:0]      best_width_ff, best_width_in;
   logic [ANGLE_BITS-1:0] best_angle_ff, best_angle_in;
   logic [DIST_W-1:0]     best_distance_ff, best_distance_in;
   logic                  best_valid_ff, best_valid_in;

   logic [DIST_W-1:0]     diff_prev, diff_prev_prev;
   logic                  hit, report, new_best, smallest;
   logic [NUM_W-1:0]      count_inc;
   logic [RUN_W-1:0]      best_width_nx;
   logic [ANGLE_BITS-1:0] best_angle_nx;
   logic [DIST_W-1:0]     best_distance_nx;
   logic                  best_valid_nx;
   rss_result_type        obj_rec, small_rec;

   // configuration
   always_comb begin
      max_range_in = max_range_ff;
      near_tol_in  = near_tol_ff;
      far_tol_in   = far_tol_ff;
      min_width_in = min_width_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MAX_RANGE: max_range_in = csr_data;
            CSR_NEAR_TOL:  near_tol_in  = csr_data;
            CSR_FAR_TOL:   far_tol_in   = csr_data;
            CSR_MIN_WIDTH: min_width_in = csr_data[CFG_WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= MAX_RANGE_RESET;
         near_tol_ff  <= NEAR_TOL_RESET;
         far_tol_ff   <= FAR_TOL_RESET;
         min_width_ff <= MIN_WIDTH_RESET;
      end else begin
         max_range_ff <= max_range_in;
         near_tol_ff  <= near_tol_in;
         far_tol_ff   <= far_tol_in;
         min_width_ff <= min_width_in;
      end
   end

   // classification and report records
   always_comb begin
      diff_prev      = (distance >= prev_sample_ff) ? distance - prev_sample_ff
                                                    : prev_sample_ff - distance;
      diff_prev_prev = (distance >= prev_prev_ff) ? distance - prev_prev_ff
                                                  : prev_prev_ff - distance;
      hit = (distance < max_range_ff) && (diff_prev <= near_tol_ff)
            && (diff_prev_prev <= far_tol_ff);

      report    = !hit && in_object_ff && (run_length_ff > min_width_ff);
      count_inc = (object_count_ff != COUNT_MAX) ? object_count_ff + 1'b1
                                                 : object_count_ff;
      new_best  = report && (!best_valid_ff || (run_length_ff < best_width_ff));

      best_valid_nx    = best_valid_ff | new_best;
      best_width_nx    = new_best ? run_length_ff : best_width_ff;
      best_distance_nx = new_best ? prev_sample_ff : best_distance_ff;
      best_angle_nx    = new_best
         ? run_start_ff + ANGLE_BITS'(run_length_ff >> 1)
         : best_angle_ff;
      smallest = end_of_sweep && best_valid_nx;

      obj_rec.kind            = KIND_OBJECT;
      obj_rec.object_number   = count_inc;
      obj_rec.angle           = run_start_ff[OUT_ANGLE_W-1:0];
      obj_rec.object_distance = prev_sample_ff;
      obj_rec.width           = run_length_ff + 1'b1;
      obj_rec.final_of_run    = !smallest;

      small_rec.kind            = KIND_SMALLEST;
      small_rec.object_number   = '0;
      small_rec.angle           = best_angle_nx[OUT_ANGLE_W-1:0];
      small_rec.object_distance = best_distance_nx;
      small_rec.width           = best_width_nx + 1'b1;
      small_rec.final_of_run    = 1'b1;

      push.count  = accept ? ({1'b0, report} + {1'b0, smallest}) : 2'd0;
      push.first  = report ? obj_rec : small_rec;
      push.second = small_rec;
   end

   // run state update
   always_comb begin
      prev_sample_in   = prev_sample_ff;
      prev_prev_in     = prev_prev_ff;
      in_object_in     = in_object_ff;
      run_length_in    = run_length_ff;
      run_start_in     = run_start_ff;
      object_count_in  = object_count_ff;
      sample_angle_in  = sample_angle_ff;
      best_width_in    = best_width_ff;
      best_angle_in    = best_angle_ff;
      best_distance_in = best_distance_ff;
      best_valid_in    = best_valid_ff;
      if (accept) begin
         if (end_of_sweep) begin
            prev_sample_in   = SAMPLE_RESET;
            prev_prev_in     = SAMPLE_RESET;
            in_object_in     = 1'b0;
            run_length_in    = '0;
            run_start_in     = '0;
            object_count_in  = '0;
            sample_angle_in  = '0;
            best_width_in    = BEST_WIDTH_RESET;
            best_angle_in    = '0;
            best_distance_in = '0;
            best_valid_in    = 1'b0;
         end else begin
            if (hit) begin
               if (!in_object_ff) begin
                  in_object_in  = 1'b1;
                  run_start_in  = sample_angle_ff;
                  run_length_in = 8'd1;
               end else if (run_length_ff < RUN_MAX) begin
                  run_length_in = run_length_ff + 1'b1;
               end
            end else if (in_object_ff) begin
               in_object_in  = 1'b0;
               run_length_in = '0;
            end
            if (report) begin
               object_count_in = count_inc;
            end
            prev_prev_in     = prev_sample_ff;
            prev_sample_in   = distance;
            sample_angle_in  = sample_angle_ff + 1'b1;
            best_width_in    = best_width_nx;
            best_angle_in    = best_angle_nx;
            best_distance_in = best_distance_nx;
            best_valid_in    = best_valid_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff   <= SAMPLE_RESET;
         prev_prev_ff     <= SAMPLE_RESET;
         in_object_ff     <= 1'b0;
         run_length_ff    <= '0;
         run_start_ff     <= '0;
         object_count_ff  <= '0;
         sample_angle_ff  <= '0;
         best_width_ff    <= BEST_WIDTH_RESET;
         best_angle_ff    <= '0;
         best_distance_ff <= '0;
         best_valid_ff    <= 1'b0;
      end else begin
         prev_sample_ff   <= prev_sample_in;
         prev_prev_ff     <= prev_prev_in;
         in_object_ff     <= in_object_in;
         run_length_ff    <= run_length_in;
         run_start_ff     <= run_start_in;
         object_count_ff  <= object_count_in;
         sample_angle_ff  <= sample_angle_in;
         best_width_ff    <= best_width_in;
         best_angle_ff    <= best_angle_in;
         best_distance_ff <= best_distance_in;
         best_valid_ff    <= best_valid_in;
      end
   end

   `RSS_ASSERT_IMPLIES(a_two_results_order, clock, reset, push.count == 2'd2, push.first.kind == KIND_OBJECT && !push.first.final_of_run && push.second.final_of_run)

endmodule

/* hdl/rss_queue.sv */
// ---------------------------------------------------------------------------
// rss_queue
// Small result FIFO: up to two writes and one read per cycle.
// ---------------------------------------------------------------------------
`include "range_sweep_object_segmenter_macros.svh"

module rss_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  rss_pkg::rss_push_type   push,
   output logic                    room,
   output logic                    head_valid,
   output rss_pkg::rss_result_type head,
   input  logic                    pop
);
   import rss_pkg::*;

   rss_result_type          mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic [QUEUE_PTR_W-1:0]  wr_ptr_next;

   always_comb begin
      wr_ptr_next = wr_ptr_ff + 1'b1;
      wr_ptr_in   = wr_ptr_ff + push.count;
      rd_ptr_in   = rd_ptr_ff + QUEUE_PTR_W'(pop);
      count_in    = count_ff + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
      // two free slots cover the worst case sample
      room        = count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
      head_valid  = count_ff != '0;
      head        = mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `RSS_ASSERT_IMPLIES(a_no_overflow, clock, reset, push.count != 2'd0, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2))
   `RSS_ASSERT_IMPLIES(a_no_underflow, clock, reset, pop, count_ff != '0)
   `RSS_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))

endmodule

/* hdl/rss_back.sv */
// ---------------------------------------------------------------------------
// rss_back
// Output register: drains the queue one transaction per cycle onto the
// result stream while the receiver is ready.
// ---------------------------------------------------------------------------
`include "range_sweep_object_segmenter_macros.svh"

module rss_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  rss_pkg::rss_result_type           head,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rss_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import rss_pkg::*;

   logic           valid_ff, valid_in;
   rss_result_type out_ff, out_in;

   always_comb begin
      pop      = head_valid && (!valid_ff || rsp_tready);
      valid_in = pop || (valid_ff && !rsp_tready);
      out_in   = pop ? head : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {out_ff.width, out_ff.object_distance, out_ff.angle,
                        out_ff.object_number};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.final_of_run;

   `RSS_ASSERT_NEXT(a_pop_fills_output, clock, reset, pop, valid_ff)

endmodule

/* hdl/range_sweep_object_segmenter.sv */
// Path: a result is written into the queue when its sample is accepted and
// then loaded into the output register that drives rsp (a stall can hold it).
// Throughput: one sample per cycle while results drain; a sample that ends an
// object at end of sweep makes two results, and the single result port then
// sets the pace at one result per cycle.
// Reset: synchronous, active high; clears run state and loads register defaults.
// ---------------------------------------------------------------------------
// range_sweep_object_segmenter
// Segments a range sweep into objects and reports each one plus the
// narrowest object at the end of the sweep.
// ---------------------------------------------------------------------------
module range_sweep_object_segmenter #(
   parameter int ANGLE_BITS = rss_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: distance[15:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rss_pkg::DIST_W-1:0]        req_tdata,
   input  logic                              req_tlast,
   // tdata: object_number[7:0], angle[15:8], object_distance[31:16],
   //        width[39:32]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rss_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser: kind[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rss_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rss_pkg::*;

   rss_push_type   push;
   rss_result_type head;
   logic           room, head_valid, pop, accept;

   assign csr_ready  = 1'b1;
   assign req_tready = room;
   assign accept     = req_tvalid && room;

   rss_front #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .distance     (req_tdata),
      .end_of_sweep (req_tlast),
      .csr_write    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .push         (push)
   );

   rss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   rss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* test/range_sweep_object_segmenter_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_sweep_object_segmenter_tb
// Drives range sweeps into the segmenter and checks every object report and
// smallest-object report against a cycle-free predictor kept in this bench.
// Covers register extremes, run saturation, count saturation and angle wrap,
// under random sender bursts and receiver stalls.
// ---------------------------------------------------------------------------
module range_sweep_object_segmenter_tb;
   import rss_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTED = 10;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} ready_mode_type;
   typedef enum int {SEG_RUN, SEG_NOISE, SEG_EMPTY} segment_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DIST_W-1:0]      req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // predictor registers and state
   logic [CFG_DIST_W-1:0]  cfg_max_range, cfg_near_tol, cfg_far_tol;
   logic [CFG_WIDTH_W-1:0] cfg_min_width;
   logic [DIST_W-1:0]      last_dist, older_dist;
   logic                   run_open;
   logic [RUN_W-1:0]       run_len;
   logic [7:0]             run_start, angle_ctr;
   logic [NUM_W-1:0]       obj_count;
   logic [RUN_W-1:0]       narrow_width;
   logic [7:0]             narrow_angle;
   logic [DIST_W-1:0]      narrow_dist;
   logic                   narrow_found;

   rss_result_type pending_reports[$];

   int failures       = 0;
   int mismatches     = 0;
   int items_sent     = 0;
   int sweeps_sent    = 0;
   int objects_seen   = 0;
   int smallest_seen  = 0;
   int cycle_count    = 0;
   int burst_left     = 0;

   range_sweep_object_segmenter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic logic [DIST_W-1:0] dist_gap(input logic [DIST_W-1:0] a, b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic rss_result_type make_report(input logic kind,
         input logic [7:0] num, ang, input logic [DIST_W-1:0] dist_val,
         input logic [7:0] wid);
      rss_result_type r;
      r.kind            = kind;
      r.object_number   = num;
      r.angle           = ang;
      r.object_distance = dist_val;
      r.width           = wid;
      r.final_of_run    = 1'b0;
      return r;
   endfunction

   function automatic void clear_sweep();
      last_dist    = SAMPLE_RESET;
      older_dist   = SAMPLE_RESET;
      run_open     = 1'b0;
      run_len      = '0;
      run_start    = '0;
      obj_count    = '0;
      angle_ctr    = '0;
      narrow_width = BEST_WIDTH_RESET;
      narrow_angle = '0;
      narrow_dist  = '0;
      narrow_found = 1'b0;
   endfunction

   function automatic void reset_predictor();
      cfg_max_range = MAX_RANGE_RESET;
      cfg_near_tol  = NEAR_TOL_RESET;
      cfg_far_tol   = FAR_TOL_RESET;
      cfg_min_width = MIN_WIDTH_RESET;
      clear_sweep();
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (rss_csr_type'(idx))
         CSR_MAX_RANGE: cfg_max_range = value;
         CSR_NEAR_TOL:  cfg_near_tol  = value;
         CSR_FAR_TOL:   cfg_far_tol   = value;
         CSR_MIN_WIDTH: cfg_min_width = value[CFG_WIDTH_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void predict_segment_reports(input logic [DIST_W-1:0] d,
                                                   input logic eos);
      rss_result_type batch[$];
      logic           hit;
      hit = (d < cfg_max_range) && (dist_gap(d, last_dist) <= cfg_near_tol)
            && (dist_gap(d, older_dist) <= cfg_far_tol);
      if (hit) begin
         if (!run_open) begin
            run_open  = 1'b1;
            run_start = angle_ctr;
            run_len   = 8'd1;
         end else if (run_len < RUN_MAX) begin
            run_len++;
         end
      end else if (run_open) begin
         if (run_len > cfg_min_width) begin
            if (obj_count < COUNT_MAX) obj_count++;
            batch.push_back(make_report(KIND_OBJECT, obj_count, run_start, last_dist,
                                        run_len + 8'd1));
            // strict compare keeps the first of equally narrow objects
            if (!narrow_found || run_len < narrow_width) begin
               narrow_found = 1'b1;
               narrow_width = run_len;
               narrow_dist  = last_dist;
               narrow_angle = run_start + (run_len >> 1);
            end
         end
         run_open = 1'b0;
         run_len  = '0;
      end
      older_dist = last_dist;
      last_dist  = d;
      angle_ctr++;
      if (eos) begin
         if (narrow_found)
            batch.push_back(make_report(KIND_SMALLEST, '0, narrow_angle, narrow_dist,
                                        narrow_width + 8'd1));
         clear_sweep();
      end
      if (batch.size() > 0) batch[batch.size() - 1].final_of_run = 1'b1;
      foreach (batch[k]) pending_reports.push_back(batch[k]);
   endfunction

   // ---------------- checker ----------------

   function automatic void check_report();
      rss_result_type want, got;
      got.kind            = rsp_tuser;
      got.object_number   = rsp_tdata[7:0];
      got.angle           = rsp_tdata[15:8];
      got.object_distance = rsp_tdata[31:16];
      got.width           = rsp_tdata[39:32];
      got.final_of_run    = rsp_tlast;
      if (got.kind == KIND_SMALLEST) smallest_seen++;
      else objects_seen++;
      if (pending_reports.size() == 0) begin
         failures++;
         mismatches++;
         if (mismatches <= MAX_REPORTED)
            $display("%0t: report with nothing expected: kind=%0d num=%0d ang=%0d",
                     $time, got.kind, got.object_number, got.angle);
         return;
      end
      want = pending_reports.pop_front();
      if (got.kind != want.kind || got.object_number != want.object_number
          || got.angle != want.angle || got.object_distance != want.object_distance
          || got.width != want.width || got.final_of_run != want.final_of_run) begin
         failures++;
         mismatches++;
         if (mismatches <= MAX_REPORTED)
            $display("%0t: mismatch exp kind=%0d num=%0d ang=%0d dist=%0d wid=%0d last=%0d",
                     $time, want.kind, want.object_number, want.angle,
                     want.object_distance, want.width, want.final_of_run,
                     "\n          got kind=%0d num=%0d ang=%0d dist=%0d wid=%0d last=%0d",
                     got.kind, got.object_number, got.angle,
                     got.object_distance, got.width, got.final_of_run);
      end
   endfunction

   // results are popped before the new sample is predicted in the same edge
   always @(posedge clock) begin
      if (reset) begin
         reset_predictor();
         pending_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_report();
         if (csr_valid && csr_ready) apply_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) predict_segment_reports(req_tdata, req_tlast);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, pending_reports.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver back-pressure: the mode is redrawn at random among always, coin, sparse and mostly ready
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 0;
   int             sparse_ctr = 0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(16, 160);
      end else begin
         mode_left--;
      end
      sparse_ctr++;
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
         READY_SPARSE: rsp_tready <= (sparse_ctr % 4 == 0);
         READY_MOSTLY: rsp_tready <= ($urandom_range(0, 7) != 0);
         default:      rsp_tready <= 1'b1;
      endcase
   end

   // ---------------- drivers ----------------

   task automatic send_sample(input logic [DIST_W-1:0] d, input logic eos);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (eos) sweeps_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 10);
      end
   endtask

   // stop sending, wait for every outstanding report, then let the pipe settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [15:0] max_rng, near_tol, far_tol,
                               input logic [7:0] min_wid);
      rss_csr_type    idx[4];
      logic [15:0]    val[4];
      idx = '{CSR_MAX_RANGE, CSR_NEAR_TOL, CSR_FAR_TOL, CSR_MIN_WIDTH};
      // upper byte of the min width write is don't-care
      val = '{max_rng, near_tol, far_tol, {8'($urandom_range(0, 255)), min_wid}};
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // random sweep: mostly well-formed object runs, with noise and empty gaps
   task automatic send_sweep(input int len);
      segment_type seg_kind;
      int          seg_left, base, jit, hi, run_cap;
      logic [15:0] d;
      seg_left = 0;
      seg_kind = SEG_NOISE;
      base     = 0;
      jit      = 0;
      for (int i = 0; i < len; i++) begin
         if (seg_left == 0) begin
            jit = int'(cfg_near_tol);
            if (int'(cfg_far_tol) < jit) jit = int'(cfg_far_tol);
            if (jit > 64) jit = 64;
            hi = int'(cfg_max_range) - 1 - jit;
            run_cap = int'(cfg_min_width) + 8;
            if (run_cap > 40) run_cap = 40;
            if ($urandom_range(0, 9) < 6 && hi >= 0) begin
               seg_kind = SEG_RUN;
               base     = $urandom_range(0, hi);
               seg_left = $urandom_range(1, run_cap);
            end else if ($urandom_range(0, 1) == 0) begin
               seg_kind = SEG_NOISE;
               seg_left = $urandom_range(1, 3);
            end else begin
               seg_kind = SEG_EMPTY;
               seg_left = $urandom_range(1, 3);
            end
         end
         case (seg_kind)
            SEG_RUN:   d = 16'(base + $urandom_range(0, jit));
            SEG_NOISE: d = 16'($urandom_range(0, 65535));
            default:   d = 16'($urandom_range(int'(cfg_max_range), 65535));
         endcase
         seg_left--;
         send_sample(d, i == len - 1);
      end
   endtask

   // ---------------- tests ----------------

   // default registers and reset history: samples just under 4000 hit at once
   task automatic test_reset_state();
      for (int i = 0; i < 8; i++) send_sample(16'(3990 - 5 * i), 1'b0);
      send_sample(16'hFFFF, 1'b1);
      wait_drained();
   endtask

   task automatic test_directed_cases();
      program_regs(16'd3000, 16'd16, 16'd32, 8'd2);
      // run ended by a sample at max range, then an equally wide run ended by
      // the end of sweep: object report first, smallest report keeps the first
      send_sample(16'd1000, 1'b0);
      send_sample(16'd1000, 1'b0);
      send_sample(16'd1000, 1'b0);
      send_sample(16'd1005, 1'b0);
      send_sample(16'd1010, 1'b0);
      send_sample(16'd3000, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      // too short a run, then a run still open at the end: no result at all
      send_sample(16'd500, 1'b0);
      send_sample(16'd500, 1'b0);
      send_sample(16'd500, 1'b0);
      send_sample(16'd3000, 1'b0);
      send_sample(16'd700, 1'b0);
      send_sample(16'd700, 1'b0);
      send_sample(16'd700, 1'b1);
      wait_drained();
   endtask

   // one run past the length limit, long enough for the angle to wrap
   task automatic test_long_run();
      program_regs(16'd50000, 16'd300, 16'd300, 8'd12);
      for (int i = 0; i < 300; i++)
         send_sample(16'(20000 + $urandom_range(0, 300)), 1'b0);
      send_sample(16'($urandom_range(50000, 65535)), 1'b1);
      wait_drained();
   endtask

   // every sample below 65535 hits: alternate hits and empties past 255 objects
   task automatic test_count_saturation();
      program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
      for (int i = 0; i < 530; i++)
         send_sample((i % 2 == 0) ? 16'($urandom_range(0, 65534)) : 16'hFFFF,
                     i == 529);
      wait_drained();
   endtask

   // nothing can hit with a zero max range; no result expected
   task automatic test_zero_range();
      program_regs(16'd0, 16'd0, 16'd0, 8'd255);
      send_sweep(20);
      send_sweep(20);
      wait_drained();
   endtask

   task automatic test_random_sweeps();
      logic [15:0] max_rng[5], near_tol[5], far_tol[5];
      logic [7:0]  min_wid[5];
      int          phase_items;
      int          sweep_len;
      max_rng  = '{16'd4000, 16'd20000, 16'd65535, 16'd3000, 16'd12000};
      near_tol = '{16'd48,   16'd0,     16'd500,   16'hFFFF, 16'd100};
      far_tol  = '{16'd64,   16'd0,     16'd900,   16'd0,    16'd40};
      min_wid  = '{8'd7,     8'd3,      8'd1,      8'd5,     8'd255};
      for (int p = 0; p < 5; p++) begin
         program_regs(max_rng[p], near_tol[p], far_tol[p], min_wid[p]);
         phase_items = 0;
         while (phase_items < 40) begin
            sweep_len = $urandom_range(6, 40);
            send_sweep(sweep_len);
            phase_items += sweep_len;
         end
         wait_drained();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_cases();
      test_long_run();
      test_count_saturation();
      test_zero_range();
      test_random_sweeps();
      wait_drained();
      if (pending_reports.size() != 0) begin
         failures++;
         $display("%0d expected reports never arrived", pending_reports.size());
      end
      $display("sent %0d samples in %0d sweeps; checked %0d object and %0d smallest reports",
               items_sent, sweeps_sent, objects_seen, smallest_seen);
      $display("register sets covered zero and full ranges; mismatches: %0d", mismatches);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/rss_pkg.sv
hdl/rss_front.sv
hdl/rss_queue.sv
hdl/rss_back.sv
hdl/range_sweep_object_segmenter.sv
test/range_sweep_object_segmenter_tb.sv
